// ===== hdl/ljc_pkg.sv =====
`timescale 1ns / 1ps
// ljc_pkg: shared widths, codes and control types of the pair energy block
package ljc_pkg;

   localparam int POS_FRAC_BITS = 16;

   localparam int POS_W   = 32;
   localparam int BOX_W   = 32;
   localparam int CHG_W   = 20;
   localparam int COEF_W  = 48;
   localparam int EN_W    = 64;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 32;

   // folded component magnitude stays below 2^32, so r2 below 3*2^64
   localparam int MAG_W   = POS_W;
   localparam int R2_W    = 2 * MAG_W + 2;
   localparam int R6_W    = 3 * R2_W;
   localparam int R12_W   = 6 * R2_W;

   localparam int SH6     = 6 * POS_FRAC_BITS - 16;
   localparam int SH12    = 12 * POS_FRAC_BITS - 16;

   localparam int MUL_OP_W = R6_W;
   localparam int MUL_P_W  = R12_W;

   localparam int NUM_W   = COEF_W + SH12;
   localparam int DEN_W   = R12_W;
   localparam int QB_W    = EN_W - 1;
   localparam int QCNT_W  = $clog2(EN_W);

   localparam int ROOT_W  = 50;
   localparam int TGT_W   = R2_W + 32;
   localparam int SQ_W    = 2 * ROOT_W + 2;
   localparam int RCNT_W  = $clog2(ROOT_W);

   localparam int QQ_W    = 2 * CHG_W;
   localparam int UQ_W    = QQ_W - 1;
   localparam int CQP_W   = CSR_DW + UQ_W;

   localparam logic [EN_W-1:0] TERM_CAP = {1'b0, {(EN_W-1){1'b1}}};
   localparam logic [EN_W-1:0] SUM_MIN  = {1'b1, {(EN_W-1){1'b0}}};

   localparam logic [BOX_W-1:0]  BOX_RESET   = 32'd655360;
   localparam logic [CSR_DW-1:0] SCALE_RESET = 32'd9105277;

   typedef enum logic [CSR_AW-1:0] {
      CSR_BOX_X = 2'd0,
      CSR_BOX_Y = 2'd1,
      CSR_BOX_Z = 2'd2,
      CSR_SCALE = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      MSEL_R4,
      MSEL_R6,
      MSEL_R12,
      MSEL_CQ
   } mul_sel_type;

   typedef enum logic [1:0] {
      DSEL_E6,
      DSEL_E12,
      DSEL_CQ
   } div_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FOLD,
      ST_R4,
      ST_R4_WAIT,
      ST_R6,
      ST_R6_WAIT,
      ST_R12,
      ST_R12_WAIT,
      ST_E6,
      ST_E6_WAIT,
      ST_E12,
      ST_E12_WAIT,
      ST_ROOT,
      ST_ROOT_WAIT,
      ST_QMUL,
      ST_QMUL_WAIT,
      ST_QDIV,
      ST_QDIV_WAIT,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic        load;
      logic        fold_en;
      logic        sq_en;
      logic [1:0]  axis;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        div_start;
      div_sel_type div_sel;
      logic        root_start;
      logic        lat_r6;
      logic        lat_r12;
      logic        lat_e6;
      logic        lat_e12;
      logic        acc_en;
      logic        emit;
   } ljc_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic root_done;
      logic last;
   } ljc_stat_type;

endpackage

// ===== hdl/ljc_req_if.sv =====
`timescale 1ns / 1ps
// ljc_req_if: atom pair item channel
interface ljc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_a_x;
   logic signed [31:0] pos_a_y;
   logic signed [31:0] pos_a_z;
   logic signed [31:0] pos_b_x;
   logic signed [31:0] pos_b_y;
   logic signed [31:0] pos_b_z;
   logic signed [19:0] charge_a;
   logic signed [19:0] charge_b;
   logic [47:0]        c6_coef;
   logic [47:0]        c12_coef;
   logic               last_pair;

   modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                   charge_a, charge_b, c6_coef, c12_coef, last_pair, input ready);
   modport sink (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                 charge_a, charge_b, c6_coef, c12_coef, last_pair, output ready);
endinterface

// ===== hdl/ljc_rsp_if.sv =====
`timescale 1ns / 1ps
// ljc_rsp_if: energy sum item channel
interface ljc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] vdw_energy;
   logic signed [63:0] cou_energy;

   modport source (output valid, vdw_energy, cou_energy, input ready);
   modport sink (input valid, vdw_energy, cou_energy, output ready);
endinterface

// ===== hdl/ljc_mul.sv =====
`timescale 1ns / 1ps
// ljc_mul: shift-add multiplier, one multiplier bit per cycle, stops early
module ljc_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ljc_pkg::MUL_OP_W-1:0] a,
   input  logic [ljc_pkg::MUL_OP_W-1:0] b,
   output logic [ljc_pkg::MUL_P_W-1:0]  p,
   output logic                         done
);
   import ljc_pkg::*;

   logic                busy_ff, busy_in;
   logic [MUL_P_W-1:0]  acc_ff, acc_in;
   logic [MUL_P_W-1:0]  mcand_ff, mcand_in;
   logic [MUL_OP_W-1:0] mplier_ff, mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         acc_in    = '0;
         mcand_in  = MUL_P_W'(a);
         mplier_in = b;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign p    = acc_ff;
   assign done = busy_ff && (mplier_ff == '0);
endmodule

// ===== hdl/ljc_div.sv =====
`timescale 1ns / 1ps
// ljc_div: restoring divider, one quotient bit per cycle, quotient capped to 63 bits
module ljc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ljc_pkg::NUM_W-1:0] n,
   input  logic [ljc_pkg::DEN_W-1:0] d,
   output logic [ljc_pkg::EN_W-1:0]  q,
   output logic                      done
);
   import ljc_pkg::*;

   localparam int DS_W = DEN_W + QB_W;
   localparam logic [QCNT_W-1:0] CNT_TOP = QCNT_W'(QB_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [DS_W-1:0]    ds_ff, ds_in;
   logic [QB_W-1:0]    qb_ff, qb_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               dz_ff, dz_in;
   logic               nz_ff, nz_in;
   logic               cap_ff, cap_in;
   logic               ge;

   assign ge = DS_W'(rem_ff) >= ds_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      ds_in   = ds_ff;
      qb_in   = qb_ff;
      cnt_in  = cnt_ff;
      dz_in   = dz_ff;
      nz_in   = nz_ff;
      cap_in  = cap_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = n;
         ds_in   = {d, {QB_W{1'b0}}};
         qb_in   = '0;
         cnt_in  = CNT_TOP;
         dz_in   = (d == '0);
         nz_in   = (n != '0);
         cap_in  = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_TOP) begin
            // overflow test against d * 2^63, zero divisor handled here
            if (dz_ff) begin
               cap_in  = nz_ff;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else if (ge) begin
               cap_in  = 1'b1;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               ds_in  = ds_ff >> 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end else begin
            if (ge) begin
               rem_in        = rem_ff - ds_ff[NUM_W-1:0];
               qb_in[cnt_ff] = 1'b1;
            end
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               ds_in  = ds_ff >> 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      ds_ff  <= ds_in;
      qb_ff  <= qb_in;
      cnt_ff <= cnt_in;
      dz_ff  <= dz_in;
      nz_ff  <= nz_in;
      cap_ff <= cap_in;
   end

   assign q    = cap_ff ? TERM_CAP : {1'b0, qb_ff};
   assign done = done_ff;
endmodule

// ===== hdl/ljc_sqrt.sv =====
`timescale 1ns / 1ps
// ljc_sqrt: digit-by-digit integer square root, one root bit per cycle
module ljc_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ljc_pkg::TGT_W-1:0]  tgt,
   output logic [ljc_pkg::ROOT_W-1:0] root,
   output logic                       done
);
   import ljc_pkg::*;

   localparam logic [RCNT_W-1:0] CNT_TOP = RCNT_W'(ROOT_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [TGT_W-1:0]   tgt_ff, tgt_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [SQ_W-1:0]    rrs_ff, rrs_in;   // root shifted left by bit + 1
   logic [SQ_W-1:0]    pw_ff, pw_in;     // 2^(2*bit)
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [RCNT_W-1:0]  cnt_ff, cnt_in;
   logic [SQ_W-1:0]    cand;
   logic [SQ_W-1:0]    rrs_next;

   assign cand = sq_ff + rrs_ff + pw_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      tgt_in   = tgt_ff;
      sq_in    = sq_ff;
      rrs_in   = rrs_ff;
      pw_in    = pw_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      rrs_next = rrs_ff;
      if (start) begin
         busy_in = 1'b1;
         tgt_in  = tgt;
         sq_in   = '0;
         rrs_in  = '0;
         pw_in   = SQ_W'(1) << (2 * (ROOT_W - 1));
         root_in = '0;
         cnt_in  = CNT_TOP;
      end else if (busy_ff) begin
         if (cand <= SQ_W'(tgt_ff)) begin
            sq_in           = cand;
            root_in[cnt_ff] = 1'b1;
            rrs_next        = rrs_ff + (pw_ff << 1);
         end
         rrs_in = rrs_next >> 1;
         pw_in  = pw_ff >> 2;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      tgt_ff  <= tgt_in;
      sq_ff   <= sq_in;
      rrs_ff  <= rrs_in;
      pw_ff   <= pw_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule

// ===== hdl/ljc_dp.sv =====
`timescale 1ns / 1ps
// ljc_dp: pair energy datapath with config registers, arithmetic units and sums
module ljc_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  ljc_pkg::ljc_cmd_type        cmd,
   output ljc_pkg::ljc_stat_type       stat,
   input  logic                        csr_we,
   input  logic [ljc_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [ljc_pkg::CSR_DW-1:0]  csr_data,
   input  logic signed [ljc_pkg::POS_W-1:0] pos_a_x,
   input  logic signed [ljc_pkg::POS_W-1:0] pos_a_y,
   input  logic signed [ljc_pkg::POS_W-1:0] pos_a_z,
   input  logic signed [ljc_pkg::POS_W-1:0] pos_b_x,
   input  logic signed [ljc_pkg::POS_W-1:0] pos_b_y,
   input  logic signed [ljc_pkg::POS_W-1:0] pos_b_z,
   input  logic signed [ljc_pkg::CHG_W-1:0] charge_a,
   input  logic signed [ljc_pkg::CHG_W-1:0] charge_b,
   input  logic [ljc_pkg::COEF_W-1:0]  c6_coef,
   input  logic [ljc_pkg::COEF_W-1:0]  c12_coef,
   input  logic                        last_pair,
   output logic signed [ljc_pkg::EN_W-1:0] vdw_energy,
   output logic signed [ljc_pkg::EN_W-1:0] cou_energy
);
   import ljc_pkg::*;

   function automatic logic [EN_W-1:0] sat_add(input logic [EN_W-1:0] a,
                                                input logic [EN_W-1:0] b);
      logic [EN_W:0] s;
      s = {a[EN_W-1], a} + {b[EN_W-1], b};
      if (s[EN_W] != s[EN_W-1]) sat_add = s[EN_W] ? SUM_MIN : TERM_CAP;
      else                      sat_add = s[EN_W-1:0];
   endfunction

   // configuration
   logic [BOX_W-1:0]  box_x_ff, box_y_ff, box_z_ff;
   logic [CSR_DW-1:0] scale_ff;

   // captured item
   logic signed [POS_W-1:0] pa_x_ff, pa_y_ff, pa_z_ff, pb_x_ff, pb_y_ff, pb_z_ff;
   logic signed [CHG_W-1:0] qa_ff, qb_ff;
   logic [COEF_W-1:0]       c6_ff, c12_ff;
   logic                    last_ff;

   // intermediate results
   logic [MAG_W-1:0]  m_ff;
   logic [R2_W-1:0]   r2_ff;
   logic [QQ_W-1:0]   qq_ff;
   logic [R6_W-1:0]   r6_ff;
   logic [R12_W-1:0]  r12_ff;
   logic [EN_W-1:0]   e6_ff, e12_ff;
   logic [EN_W-1:0]   vdw_sum_ff, vdw_sum_in;
   logic [EN_W-1:0]   cou_sum_ff, cou_sum_in;
   logic [EN_W-1:0]   vdw_out_ff, cou_out_ff;

   // fold
   logic signed [POS_W-1:0] fa, fb;
   logic [BOX_W-1:0]        fbox;
   logic [POS_W:0]          dif;
   logic signed [POS_W+2:0] dif2, boxs;
   logic [POS_W+1:0]        dn, mag;

   // units
   logic [MUL_OP_W-1:0] mul_a, mul_b;
   logic [MUL_P_W-1:0]  mul_p;
   logic                mul_done;
   logic [NUM_W-1:0]    div_n;
   logic [DEN_W-1:0]    div_d;
   logic [EN_W-1:0]     div_q;
   logic                div_done;
   logic [ROOT_W-1:0]   root;
   logic                root_done;

   logic signed [QQ_W-1:0] qq;
   logic [UQ_W-1:0]     uq;
   logic [EN_W-1:0]     lj, ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= BOX_RESET;
         box_y_ff <= BOX_RESET;
         box_z_ff <= BOX_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BOX_X: box_x_ff <= csr_data;
            CSR_BOX_Y: box_y_ff <= csr_data;
            CSR_BOX_Z: box_z_ff <= csr_data;
            CSR_SCALE: scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // minimum image fold of one axis
   always_comb begin
      case (cmd.axis)
         2'd0: begin
            fa = pa_x_ff; fb = pb_x_ff; fbox = box_x_ff;
         end
         2'd1: begin
            fa = pa_y_ff; fb = pb_y_ff; fbox = box_y_ff;
         end
         default: begin
            fa = pa_z_ff; fb = pb_z_ff; fbox = box_z_ff;
         end
      endcase
      dif  = {fa[POS_W-1], fa} - {fb[POS_W-1], fb};
      dif2 = {dif[POS_W], dif, 1'b0};
      boxs = {3'b000, fbox};
      if (dif2 > boxs)       dn = {dif[POS_W], dif} - {2'b00, fbox};
      else if (dif2 < -boxs) dn = {dif[POS_W], dif} + {2'b00, fbox};
      else                   dn = {dif[POS_W], dif};
      mag = dn[POS_W+1] ? (~dn + 1'b1) : dn;
   end

   assign qq = qa_ff * qb_ff;
   assign uq = qq_ff[QQ_W-1] ? UQ_W'(~qq_ff + 1'b1) : qq_ff[UQ_W-1:0];

   always_comb begin
      case (cmd.mul_sel)
         MSEL_R4: begin
            mul_a = MUL_OP_W'(r2_ff);
            mul_b = MUL_OP_W'(r2_ff);
         end
         MSEL_R6: begin
            mul_a = mul_p[MUL_OP_W-1:0];
            mul_b = MUL_OP_W'(r2_ff);
         end
         MSEL_R12: begin
            mul_a = r6_ff;
            mul_b = r6_ff;
         end
         default: begin
            mul_a = MUL_OP_W'(scale_ff);
            mul_b = MUL_OP_W'(uq);
         end
      endcase
   end

   always_comb begin
      case (cmd.div_sel)
         DSEL_E6: begin
            div_n = NUM_W'(c6_ff) << SH6;
            div_d = DEN_W'(r6_ff);
         end
         DSEL_E12: begin
            div_n = NUM_W'(c12_ff) << SH12;
            div_d = r12_ff;
         end
         default: begin
            div_n = NUM_W'(mul_p[CQP_W-1:0]) << POS_FRAC_BITS;
            div_d = DEN_W'(root);
         end
      endcase
   end

   ljc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p),
      .done  (mul_done)
   );

   ljc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .n     (div_n),
      .d     (div_d),
      .q     (div_q),
      .done  (div_done)
   );

   ljc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.root_start),
      .tgt   ({r2_ff, 32'd0}),
      .root  (root),
      .done  (root_done)
   );

   // lj difference fits since both terms are capped below 2^63
   assign lj = e12_ff - e6_ff;
   assign ce = qq_ff[QQ_W-1] ? (~div_q + 1'b1) : div_q;

   always_comb begin
      vdw_sum_in = vdw_sum_ff;
      cou_sum_in = cou_sum_ff;
      if (cmd.acc_en) begin
         vdw_sum_in = sat_add(vdw_sum_ff, lj);
         cou_sum_in = sat_add(cou_sum_ff, ce);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vdw_sum_ff <= '0;
         cou_sum_ff <= '0;
      end else if (cmd.emit) begin
         vdw_sum_ff <= '0;
         cou_sum_ff <= '0;
      end else begin
         vdw_sum_ff <= vdw_sum_in;
         cou_sum_ff <= cou_sum_in;
      end
      if (cmd.emit) begin
         vdw_out_ff <= vdw_sum_in;
         cou_out_ff <= cou_sum_in;
      end
      if (cmd.load) begin
         pa_x_ff <= pos_a_x;
         pa_y_ff <= pos_a_y;
         pa_z_ff <= pos_a_z;
         pb_x_ff <= pos_b_x;
         pb_y_ff <= pos_b_y;
         pb_z_ff <= pos_b_z;
         qa_ff   <= charge_a;
         qb_ff   <= charge_b;
         c6_ff   <= c6_coef;
         c12_ff  <= c12_coef;
         last_ff <= last_pair;
         r2_ff   <= '0;
      end else if (cmd.sq_en) begin
         r2_ff <= r2_ff + R2_W'(m_ff * m_ff);
      end
      if (cmd.fold_en) m_ff <= mag[MAG_W-1:0];
      if (cmd.fold_en && cmd.axis == 2'd0) qq_ff <= qq;
      if (cmd.lat_r6)  r6_ff  <= mul_p[R6_W-1:0];
      if (cmd.lat_r12) r12_ff <= mul_p;
      if (cmd.lat_e6)  e6_ff  <= div_q;
      if (cmd.lat_e12) e12_ff <= div_q;
   end

   assign stat.mul_done  = mul_done;
   assign stat.div_done  = div_done;
   assign stat.root_done = root_done;
   assign stat.last      = last_ff;
   assign vdw_energy     = vdw_out_ff;
   assign cou_energy     = cou_out_ff;
endmodule

// ===== hdl/ljc_ctrl.sv =====
`timescale 1ns / 1ps
// ljc_ctrl: sequencer stepping one pair through fold, powers, square root, charge product, divides and sums
module ljc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ljc_pkg::ljc_stat_type stat,
   output ljc_pkg::ljc_cmd_type  cmd
);
   import ljc_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       blocked;

   assign blocked = stat.last && rsp_valid_ff && !rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_FOLD;
         ST_FOLD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) state_in = ST_R4;
         end
         ST_R4:        state_in = ST_R4_WAIT;
         ST_R4_WAIT:   if (stat.mul_done) state_in = ST_R6;
         ST_R6:        state_in = ST_R6_WAIT;
         ST_R6_WAIT:   if (stat.mul_done) state_in = ST_R12;
         ST_R12:       state_in = ST_R12_WAIT;
         ST_R12_WAIT:  if (stat.mul_done) state_in = ST_E6;
         ST_E6:        state_in = ST_E6_WAIT;
         ST_E6_WAIT:   if (stat.div_done) state_in = ST_E12;
         ST_E12:       state_in = ST_E12_WAIT;
         ST_E12_WAIT:  if (stat.div_done) state_in = ST_ROOT;
         ST_ROOT:      state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: if (stat.root_done) state_in = ST_QMUL;
         ST_QMUL:      state_in = ST_QMUL_WAIT;
         ST_QMUL_WAIT: if (stat.mul_done) state_in = ST_QDIV;
         ST_QDIV:      state_in = ST_QDIV_WAIT;
         ST_QDIV_WAIT: if (stat.div_done) state_in = ST_ACC;
         ST_ACC:       if (!blocked) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MSEL_R4;
      cmd.div_sel = DSEL_E6;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_FOLD: begin
            cmd.fold_en = (cnt_ff != 2'd3);
            cmd.sq_en   = (cnt_ff != 2'd0);
            cmd.axis    = cnt_ff;
         end
         ST_R4: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_R4;
         end
         ST_R6: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_R6;
         end
         ST_R6_WAIT:  cmd.lat_r6 = stat.mul_done;
         ST_R12: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_R12;
         end
         ST_R12_WAIT: cmd.lat_r12 = stat.mul_done;
         ST_E6: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_E6;
         end
         ST_E6_WAIT:  cmd.lat_e6 = stat.div_done;
         ST_E12: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_E12;
         end
         ST_E12_WAIT: cmd.lat_e12 = stat.div_done;
         ST_ROOT:     cmd.root_start = 1'b1;
         ST_QMUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_CQ;
         end
         ST_QDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_CQ;
         end
         ST_QDIV_WAIT: cmd.div_sel = DSEL_CQ;
         ST_ACC: begin
            cmd.acc_en = !blocked;
            cmd.emit   = !blocked && stat.last;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== hdl/lj_coulomb_pair_energy.sv =====
`timescale 1ns / 1ps
// lj_coulomb_pair_energy: top level, lennard-jones plus coulomb pair energy accumulator
// one item at a time: a new pair is taken only once the previous one has left the accumulate step;
//   a closing item also waits while the previous sum is still unread in the output register
// reset (synchronous, active high): sums cleared, boxes 10 nm, coulomb scale 138.9355
module lj_coulomb_pair_energy (
   input  logic                        clock,
   input  logic                        reset,
   ljc_req_if.sink                     req,
   ljc_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  logic [ljc_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [ljc_pkg::CSR_DW-1:0]  csr_data
);
   import ljc_pkg::*;

   ljc_cmd_type  cmd;
   ljc_stat_type stat;

   // sequencer: item handshake, unit starts and result latching
   ljc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: fold, r2, r^6, r^12, sqrt, three divides, saturating sums
   ljc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data),
      .pos_a_x    (req.pos_a_x),
      .pos_a_y    (req.pos_a_y),
      .pos_a_z    (req.pos_a_z),
      .pos_b_x    (req.pos_b_x),
      .pos_b_y    (req.pos_b_y),
      .pos_b_z    (req.pos_b_z),
      .charge_a   (req.charge_a),
      .charge_b   (req.charge_b),
      .c6_coef    (req.c6_coef),
      .c12_coef   (req.c12_coef),
      .last_pair  (req.last_pair),
      .vdw_energy (rsp.vdw_energy),
      .cou_energy (rsp.cou_energy)
   );
endmodule

// ===== hdl/ljc_chk.sv =====
`timescale 1ns / 1ps
// ljc_chk: port checker for the pair energy block and its bind
module ljc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] vdw_energy,
   input logic [63:0] cou_energy
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(vdw_energy) && $stable(cou_energy))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while another is in work");
endmodule

bind lj_coulomb_pair_energy ljc_chk u_ljc_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .vdw_energy (rsp.vdw_energy),
   .cou_energy (rsp.cou_energy)
);

// ===== tb/lj_coulomb_pair_energy_test.sv =====
`timescale 1ns / 1ps
// lj_coulomb_pair_energy_test: self-checking bench for the pair energy accumulator
module lj_coulomb_pair_energy_test;
   import ljc_pkg::*;

   localparam int   CLK_HALF    = 1;
   localparam int   TAIL_CYCLES = 700;       // covers the worst per-item latency
   localparam int   CYCLE_LIMIT = 1500000;
   localparam int   HOLD_CYCLES = 3000;      // long receiver hold-off
   localparam int   HOLD_AT     = 100;       // random item index that triggers it
   localparam int   ITEMS_PER_PHASE = 130;
   localparam int   NUM_PHASES  = 5;
   localparam int   WIDE_W      = 400;       // r2^6 stays below 2^396

   typedef struct {
      logic signed [POS_W-1:0]  ax, ay, az, bx, by, bz;
      logic signed [CHG_W-1:0]  qa, qb;
      logic [COEF_W-1:0]        c6, c12;
      logic                     last;
   } pair_type;

   typedef struct {
      logic signed [EN_W-1:0] vdw;
      logic signed [EN_W-1:0] cou;
   } energy_type;

   typedef struct {
      pair_type   pair;
      logic       typed;          // expected result given in the row itself
      energy_type energy;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_data = '0;

   ljc_req_if req ();
   ljc_rsp_if rsp ();

   lj_coulomb_pair_energy u_top (
      .clock    (clock),
      .reset    (reset),
      .req      (req.sink),
      .rsp      (rsp.source),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_data (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // predictor state: register copies and running sums
   logic [BOX_W-1:0]       box_len [3];
   logic [CSR_DW-1:0]      scale_reg;
   logic signed [EN_W-1:0] vdw_acc, cou_acc;

   energy_type energy_q [$];
   int      errors = 0;
   int      cycle = 0;
   logic    quiet = 1'b0;     // no idling on either side
   logic    hold_req = 1'b0;  // ask receiver for a long hold-off

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // minimum-image fold of one axis, squared
   function automatic logic [67:0] fold_sq(logic signed [31:0] a, logic signed [31:0] b,
                                           logic [31:0] blen);
      longint d, bl;
      longint unsigned m;
      d  = longint'(a) - longint'(b);
      bl = longint'({32'b0, blen});
      if (2 * d > bl) d -= bl;
      else if (2 * d < -bl) d += bl;
      m = (d < 0) ? longint'(-d) : d;
      return 68'(m * m);
   endfunction

   // floor quotient capped at the term limit; zero divisor gives cap or zero
   function automatic logic [EN_W-1:0] quot_cap(logic [WIDE_W-1:0] n, logic [WIDE_W-1:0] d);
      logic [WIDE_W-1:0] q;
      if (d == 0) return (n == 0) ? '0 : TERM_CAP;
      q = n / d;
      if (q > {{(WIDE_W-EN_W){1'b0}}, TERM_CAP}) return TERM_CAP;
      return q[EN_W-1:0];
   endfunction

   function automatic logic signed [EN_W-1:0] sat_add(logic signed [EN_W-1:0] a,
                                                    logic signed [EN_W-1:0] b);
      logic signed [EN_W:0] s;
      s = {a[EN_W-1], a} + {b[EN_W-1], b};
      if (s[EN_W] != s[EN_W-1]) return s[EN_W] ? SUM_MIN : TERM_CAP;
      return s[EN_W-1:0];
   endfunction

   // energy terms of one pair under the current register copies
   function automatic energy_type pair_terms(pair_type p);
      logic [WIDE_W-1:0] r2, r6, r12, num;
      logic [99:0]       tgt;
      logic [127:0]      sq;
      logic [49:0]       root, cand;
      logic [EN_W-1:0]   e6, e12, cq;
      longint            qq;
      longint unsigned   uq;
      energy_type        e;
      r2 = fold_sq(p.ax, p.bx, box_len[0]) + fold_sq(p.ay, p.by, box_len[1])
         + fold_sq(p.az, p.bz, box_len[2]);
      r6  = r2 * r2 * r2;
      r12 = r6 * r6;
      num = WIDE_W'(p.c6) << SH6;
      e6  = quot_cap(num, r6);
      num = WIDE_W'(p.c12) << SH12;
      e12 = quot_cap(num, r12);
      e.vdw = $signed(e12) - $signed(e6);
      // integer square root of r2 * 2^32, bit by bit
      tgt  = {r2[67:0], 32'b0};
      root = '0;
      for (int bit_i = 49; bit_i >= 0; bit_i--) begin
         cand = root | (50'b1 << bit_i);
         sq   = 128'(cand) * 128'(cand);
         if (sq <= 128'(tgt)) root = cand;
      end
      qq  = longint'(p.qa) * longint'(p.qb);
      uq  = (qq < 0) ? longint'(-qq) : qq;
      num = (WIDE_W'(scale_reg) * WIDE_W'(uq)) << POS_FRAC_BITS;
      cq  = quot_cap(num, WIDE_W'(root));
      e.cou = (qq < 0) ? -$signed(cq) : $signed(cq);
      return e;
   endfunction

   // accept one pair into the predictor; last pair queues the expected sums
   task automatic predict_pair(pair_type p, logic typed, energy_type typed_e);
      energy_type t;
      t = pair_terms(p);
      vdw_acc = sat_add(vdw_acc, t.vdw);
      cou_acc = sat_add(cou_acc, t.cou);
      if (p.last) begin
         if (typed) energy_q.push_back(typed_e);
         else energy_q.push_back('{vdw: vdw_acc, cou: cou_acc});
         vdw_acc = '0;
         cou_acc = '0;
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic pair_type make_pair(logic [31:0] ax, ay, az, bx, by, bz,
                                          logic [19:0] qa, qb, logic [47:0] c6, c12,
                                          logic last);
      pair_type p;
      p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
      p.qa = qa; p.qb = qb; p.c6 = c6; p.c12 = c12; p.last = last;
      return p;
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   // mostly nearby atoms with moderate values, some raw bit noise
   function automatic pair_type random_pair();
      pair_type p;
      logic [31:0] off [3];
      if ($urandom_range(99) < 30) begin
         p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       CHG_W'($urandom), CHG_W'($urandom), rand48(), rand48(), 1'b0);
      end else begin
         for (int i = 0; i < 3; i++)
            off[i] = $urandom_range(32'h0006_0000) - 32'h0003_0000;
         p.ax = $urandom_range(32'h000A_0000);
         p.ay = $urandom_range(32'h000A_0000);
         p.az = $urandom_range(32'h000A_0000);
         p.bx = p.ax + off[0];
         p.by = p.ay + off[1];
         p.bz = p.az + off[2];
         p.qa = CHG_W'($urandom_range(32'h2_0000) - 32'h1_0000);
         p.qb = CHG_W'($urandom_range(32'h2_0000) - 32'h1_0000);
         p.c6  = rand48() >> $urandom_range(40);
         p.c12 = rand48() >> $urandom_range(40);
      end
      p.last = ($urandom_range(3) == 0);
      return p;
   endfunction

   task automatic write_regs(logic [31:0] bx, by, bz, sc);
      logic [31:0] vals [4];
      csr_idx_type idx [4];
      vals = '{bx, by, bz, sc};
      idx  = '{CSR_BOX_X, CSR_BOX_Y, CSR_BOX_Z, CSR_SCALE};
      for (int i = 0; i < 4; i++) begin
         csr_we   <= 1'b1;
         csr_addr <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      box_len[0] = bx; box_len[1] = by; box_len[2] = bz;
      scale_reg  = sc;
   endtask

   // offer one pair and hold it until the block takes it
   task automatic send_pair(pair_type p, logic typed, energy_type typed_e);
      req.valid     <= 1'b1;
      req.pos_a_x   <= p.ax; req.pos_a_y <= p.ay; req.pos_a_z <= p.az;
      req.pos_b_x   <= p.bx; req.pos_b_y <= p.by; req.pos_b_z <= p.bz;
      req.charge_a  <= p.qa; req.charge_b <= p.qb;
      req.c6_coef   <= p.c6; req.c12_coef <= p.c12;
      req.last_pair <= p.last;
      do @(posedge clock); while (!req.ready);
      predict_pair(p, typed, typed_e);
      // random gaps between items, none while quiet
      if (!quiet && $urandom_range(99) < 9) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (energy_q.size() != 0) @(posedge clock);
      // a pair that closes no sum may still be in flight
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // directed table
   // ---------------------------------------------------------------
   row_type rows [$];

   task automatic add_row(pair_type p, logic typed = 1'b0,
                          logic [63:0] vdw = '0, logic [63:0] cou = '0);
      row_type r;
      r.pair = p; r.typed = typed; r.energy = '{vdw: vdw, cou: cou};
      rows.push_back(r);
   endtask

   task automatic build_table();
      localparam logic [31:0] PMAX = 32'h7FFF_FFFF, PMIN = 32'h8000_0000;
      localparam logic [19:0] QMAX = 20'h7_FFFF, QMIN = 20'h8_0000;
      localparam logic [47:0] CMAX = 48'hFFFF_FFFF_FFFF;
      // coincident atoms, nothing to add
      add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, '0, '0);
      // coincident atoms: a nonzero numerator takes the cap
      add_row(make_pair(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 0, 0, 0, CMAX, 1),
              1'b1, TERM_CAP, '0);
      add_row(make_pair(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 0, QMAX, CMAX, 0, 1),
              1'b1, -TERM_CAP, '0);
      add_row(make_pair(5, 6, 7, 5, 6, 7, QMAX, QMAX, CMAX, CMAX, 1), 1'b1, '0, TERM_CAP);
      add_row(make_pair(0, 0, 0, 0, 0, 0, QMIN, QMAX, 0, 0, 1), 1'b1, '0, -TERM_CAP);
      // sums saturate high and low
      add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, CMAX, 0));
      add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, CMAX, 1), 1'b1, TERM_CAP, '0);
      add_row(make_pair(0, 0, 0, 0, 0, 0, QMIN, QMAX, 0, 0, 0));
      add_row(make_pair(0, 0, 0, 0, 0, 0, QMIN, QMAX, 0, 0, 0));
      add_row(make_pair(0, 0, 0, 0, 0, 0, QMIN, QMAX, 0, 0, 1), 1'b1, '0, SUM_MIN);
      // field extremes, folded across the box
      add_row(make_pair(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, QMAX, QMIN, CMAX, CMAX, 1));
      add_row(make_pair(PMIN, 0, PMAX, PMAX, 0, PMIN, QMIN, QMIN, CMAX, 0, 1));
      // half-box edge on each axis
      add_row(make_pair(32'h0005_0000, 0, 0, 0, 0, 0, 20'h1_0000, 20'h1_0000,
                        48'h0000_1000_0000, 48'h0000_0001_0000, 0));
      add_row(make_pair(0, 32'h0005_0001, 0, 0, 0, 0, 20'h1_0000, QMIN, 48'h1, 48'h1, 0));
      add_row(make_pair(0, 0, 0, 0, 0, 32'h0005_0001, QMAX, 20'h1_0000, CMAX, CMAX, 1));
      // one lsb apart: tiny distance, huge terms
      add_row(make_pair(1, 0, 0, 0, 0, 0, 20'h1, 20'h1, 48'h1, 48'h1, 1));
      // unit distance and a shorter one, with typical values
      add_row(make_pair(32'h0001_0000, 0, 0, 0, 0, 0, 20'h0_6666, 20'hF_999A,
                        48'h0000_0100_0000, 48'h0000_0000_1000, 0));
      add_row(make_pair(0, 32'h0000_4000, 32'h0000_4000, 0, 0, 0, 20'h0_8000, 20'h0_8000,
                        48'h0000_0010_0000, 48'h0000_0000_0100, 1));
   endtask

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   // receiver: random stalls, one long hold-off, quiet stretch
   int hold_left = 0;
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (hold_req && hold_left == 0) begin
         hold_left <= HOLD_CYCLES;
         rsp.ready <= 1'b0;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         if (hold_left == 1) hold_left <= -1;   // hold-off done, never again
         rsp.ready <= quiet || ($urandom_range(99) >= 9);
      end
   end

   always @(posedge clock) begin
      energy_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (energy_q.size() == 0) begin
            $error("result with no pending sum: vdw %0d cou %0d",
                   rsp.vdw_energy, rsp.cou_energy);
            errors++;
         end else begin
            e = energy_q.pop_front();
            if (rsp.vdw_energy !== e.vdw) begin
               $error("vdw_energy expected %0d actual %0d", e.vdw, rsp.vdw_energy);
               errors++;
            end
            if (rsp.cou_energy !== e.cou) begin
               $error("cou_energy expected %0d actual %0d", e.cou, rsp.cou_energy);
               errors++;
            end
         end
      end
   end

   // overall watchdog
   always @(posedge clock) begin
      if (cycle > CYCLE_LIMIT) begin
         $display("[lj_coulomb_pair_energy] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      logic [31:0] s [4];
      int rand_idx;
      req.valid = 1'b0;
      req.pos_a_x = '0; req.pos_a_y = '0; req.pos_a_z = '0;
      req.pos_b_x = '0; req.pos_b_y = '0; req.pos_b_z = '0;
      req.charge_a = '0; req.charge_b = '0;
      req.c6_coef = '0; req.c12_coef = '0; req.last_pair = 1'b0;
      box_len[0] = BOX_RESET; box_len[1] = BOX_RESET; box_len[2] = BOX_RESET;
      scale_reg = SCALE_RESET;
      vdw_acc = '0;
      cou_acc = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under the reset settings
      build_table();
      foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].energy);
      drain();

      // random phases, each under its own register settings
      rand_idx = 0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: s = '{BOX_RESET, BOX_RESET, BOX_RESET, SCALE_RESET};
            1: s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            2: s = '{32'h0, 32'h0, 32'h0, 32'h0};
            3: s = '{32'h1, $urandom_range(32'h2_0000), $urandom_range(1, 32'h4_0000),
                     $urandom_range(32'h00FF_FFFF)};
            default: s = '{$urandom, $urandom, $urandom, $urandom};
         endcase
         write_regs(s[0], s[1], s[2], s[3]);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // a long run with no idling on either side
            quiet <= (rand_idx >= 350 && rand_idx < 450);
            if (rand_idx == HOLD_AT) hold_req <= 1'b1;
            send_pair(random_pair(), 1'b0, '{vdw: '0, cou: '0});
            rand_idx++;
         end
         // close the open sum so the phase ends with nothing carried over
         send_pair(make_pair(0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 1),
                   1'b0, '{vdw: '0, cou: '0});
         drain();
      end

      if (errors == 0 && energy_q.size() == 0) begin
         $display("[lj_coulomb_pair_energy] OK");
      end else begin
         $display("[lj_coulomb_pair_energy] ERROR");
      end
      $finish;
   end

endmodule
